/* sv/twmd_pkg.sv */
// shared types and constants for the three-way descending merge
package twmd_pkg;

    localparam int NUM_LISTS = 3;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int DATA_W = 32;
    localparam int ID_W = 2;
    localparam int LIMIT_W = 6;

    localparam logic [LIMIT_W-1:0] MAX_OUT = 6'd48;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd48;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic any_valid;
        logic remain_one;
        logic out_free;
    } t_stat;

endpackage

/* sv/three_way_merge_descending_top.sv */
// top level of the three-way descending merge
// Words on the input stream are appended to list 0, 1 or 2 (tuser) back
// to back while the input is ready; a word with tlast set is stored and
// starts the merge. After a prime state that primes the bank read registers,
// the merge emits one result per cycle whenever the output register is free,
// the rate being set by the single registered read port of each list bank
// and the one-word output register. The input is not ready during the
// merge. Each list holds LIST_DEPTH words; further words are dropped and
// flagged on every result of the batch.
module three_way_merge_descending_top #(
    parameter int LIST_DEPTH = twmd_pkg::LIST_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // elem_value
    input  logic                         s_axis_tlast,  // start_merge
    input  logic [1:0]                   s_axis_tuser,  // list_id
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // merged_value
    output logic                         m_axis_tlast,  // last_of_run
    output logic [2:0]                   m_axis_tuser,  // source_list, dropped
    input  logic                         i_cfg_we,
    input  logic [twmd_pkg::LIMIT_W-1:0] i_cfg_wdata   // out_limit
);

    twmd_pkg::t_cmd  w_cmd;
    twmd_pkg::t_stat w_stat;
    logic            w_dropped;
    logic [1:0]      w_src;

    twmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    twmd_dpath #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_id      (s_axis_tuser),
        .i_in_data    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_src    (w_src),
        .o_out_dropped(w_dropped),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {w_dropped, w_src};

    a_no_load_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !s_axis_tready)
        else $error("input ready during merge step");

    a_step_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_stat.out_free)
        else $error("merge step with output register full");

    a_step_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |=> m_axis_tvalid)
        else $error("merge step lost its output word");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> !w_stat.any_valid)
        else $error("lists not empty after batch clear");

endmodule

/* sv/twmd_bank.sv */
// one list bank: single write port, registered read port
module twmd_bank #(
    parameter int DEPTH = twmd_pkg::LIST_DEPTH_DEF,
    parameter int AW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [twmd_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [twmd_pkg::DATA_W-1:0] o_rdata
);

    logic [twmd_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [twmd_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/twmd_ctrl.sv */
// merge controller: load, prime and merge sequencing, limit register
module twmd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_last,
    input  logic                         i_cfg_we,
    input  logic [twmd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  twmd_pkg::t_stat              i_stat,
    output logic                         o_in_ready,
    output twmd_pkg::t_cmd               o_cmd
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [twmd_pkg::LIMIT_W-1:0] r_out_limit;
    logic [twmd_pkg::LIMIT_W-1:0] r_lim, n_lim;
    logic [twmd_pkg::LIMIT_W-1:0] r_emit, n_emit;
    logic                         w_done;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_done = (r_emit == r_lim) || !i_stat.any_valid;

    always_comb begin
        n_state = r_state;
        n_lim = r_lim;
        n_emit = r_emit;
        o_cmd = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_emit = '0;
                n_lim = (r_out_limit > twmd_pkg::MAX_OUT) ? twmd_pkg::MAX_OUT : r_out_limit;
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (w_done) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_LOAD;
                end else if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.last = i_stat.remain_one ||
                                 ((r_emit + twmd_pkg::LIMIT_W'(1)) == r_lim);
                    n_emit = r_emit + twmd_pkg::LIMIT_W'(1);
                    if (o_cmd.last) begin
                        o_cmd.clear = 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_out_limit <= twmd_pkg::LIMIT_RESET;
            r_lim <= '0;
            r_emit <= '0;
        end else begin
            r_state <= n_state;
            r_lim <= n_lim;
            r_emit <= n_emit;
            if (i_cfg_we) begin
                r_out_limit <= i_cfg_wdata;
            end
        end
    end

endmodule

/* sv/twmd_dpath.sv */
// merge datapath: list banks, counts, read pointers, head compare, output register
module twmd_dpath #(
    parameter int LIST_DEPTH = twmd_pkg::LIST_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  twmd_pkg::t_cmd              i_cmd,
    input  logic [twmd_pkg::ID_W-1:0]   i_in_id,
    input  logic [twmd_pkg::DATA_W-1:0] i_in_data,
    input  logic                        i_out_ready,
    output twmd_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    output logic [twmd_pkg::DATA_W-1:0] o_out_data,
    output logic [twmd_pkg::ID_W-1:0]   o_out_src,
    output logic                        o_out_dropped,
    output logic                        o_out_last
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SUM_W = CNT_W + 2;

    logic [CNT_W-1:0]              r_cnt [twmd_pkg::NUM_LISTS];
    logic [CNT_W-1:0]              n_cnt [twmd_pkg::NUM_LISTS];
    logic [CNT_W-1:0]              r_ptr [twmd_pkg::NUM_LISTS];
    logic [CNT_W-1:0]              n_ptr [twmd_pkg::NUM_LISTS];
    logic                          r_ovf, n_ovf;
    logic [twmd_pkg::NUM_LISTS-1:0] w_we;
    logic [twmd_pkg::NUM_LISTS-1:0] w_head_v;
    logic [twmd_pkg::DATA_W-1:0]   w_rdata [twmd_pkg::NUM_LISTS];
    logic                          w_found;
    logic [twmd_pkg::ID_W-1:0]     w_win;
    logic [twmd_pkg::DATA_W-1:0]   w_best;
    logic [SUM_W-1:0]              w_remain;

    logic                          r_out_valid;
    logic [twmd_pkg::DATA_W-1:0]   r_out_data;
    logic [twmd_pkg::ID_W-1:0]     r_out_src;
    logic                          r_out_dropped;
    logic                          r_out_last;

    genvar g;
    generate
        for (g = 0; g < twmd_pkg::NUM_LISTS; g++) begin : g_bank
            twmd_bank #(
                .DEPTH(LIST_DEPTH),
                .AW   (AW)
            ) u_bank (
                .i_clk  (i_clk),
                .i_we   (w_we[g]),
                .i_waddr(r_cnt[g][AW-1:0]),
                .i_wdata(i_in_data),
                .i_raddr(n_ptr[g][AW-1:0]),
                .o_rdata(w_rdata[g])
            );
            assign w_head_v[g] = (r_ptr[g] < r_cnt[g]);
        end
    endgenerate

    // largest head, higher list wins ties
    always_comb begin
        w_found = 1'b0;
        w_win = '0;
        w_best = '0;
        for (int l = 0; l < twmd_pkg::NUM_LISTS; l++) begin
            if (w_head_v[l] && (!w_found || !($signed(w_best) > $signed(w_rdata[l])))) begin
                w_found = 1'b1;
                w_win = twmd_pkg::ID_W'(l);
                w_best = w_rdata[l];
            end
        end
    end

    always_comb begin
        w_remain = '0;
        for (int l = 0; l < twmd_pkg::NUM_LISTS; l++) begin
            w_remain = w_remain + SUM_W'(r_cnt[l] - r_ptr[l]);
        end
    end

    always_comb begin
        n_ovf = r_ovf;
        w_we = '0;
        for (int l = 0; l < twmd_pkg::NUM_LISTS; l++) begin
            n_cnt[l] = r_cnt[l];
            n_ptr[l] = r_ptr[l];
            if (i_cmd.load && (i_in_id == twmd_pkg::ID_W'(l))) begin
                if (r_cnt[l] < CNT_W'(LIST_DEPTH)) begin
                    w_we[l] = 1'b1;
                    n_cnt[l] = r_cnt[l] + CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (i_cmd.step && (w_win == twmd_pkg::ID_W'(l))) begin
                n_ptr[l] = r_ptr[l] + CNT_W'(1);
            end
            if (i_cmd.clear) begin
                n_cnt[l] = '0;
                n_ptr[l] = '0;
            end
        end
        if (i_cmd.clear) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < twmd_pkg::NUM_LISTS; l++) begin
                r_cnt[l] <= '0;
                r_ptr[l] <= '0;
            end
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ptr <= n_ptr;
            r_ovf <= n_ovf;
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_data <= w_best;
            r_out_src <= w_win;
            r_out_dropped <= r_ovf;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_stat.any_valid = w_found;
    assign o_stat.remain_one = (w_remain == SUM_W'(1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    assign o_out_src = r_out_src;
    assign o_out_dropped = r_out_dropped;
    assign o_out_last = r_out_last;

endmodule
